// ===== hw/rtl/sliding_window_spike_rate_defines.svh =====
// Assertion macros shared by the sliding window spike rate RTL.
`ifndef SLIDING_WINDOW_SPIKE_RATE_DEFINES_SVH
`define SLIDING_WINDOW_SPIKE_RATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWSR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWSR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/swsr_pkg.sv =====
`default_nettype none
package swsr_pkg;

	localparam int TIME_BITS      = 32;
	localparam int HALF_BITS      = 31;
	localparam int WCOUNT_BITS    = 9;
	localparam int SCALE_BITS     = 32;
	localparam int INDEX_BITS     = 8;
	localparam int COUNT_OUT_BITS = 20;
	localparam int RATE_BITS      = 48;
	localparam int CMD_BITS       = 2;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 32;

	// Item commands. The fourth code is unused and does nothing.
	localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_START  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HALF   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WCOUNT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = 3'd4;

	localparam logic [TIME_BITS-1:0]   START_RESET  = 32'd0;
	localparam logic [TIME_BITS-1:0]   STEP_RESET   = 32'd100000;
	localparam logic [HALF_BITS-1:0]   HALF_RESET   = 31'd500000;
	localparam logic [WCOUNT_BITS-1:0] WCOUNT_RESET = 9'd0;
	localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 32'd65536;

	localparam logic [63:0] RATE_MAX = (64'd1 << RATE_BITS) - 64'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic add_issue;
		logic clear_wr;
		logic read_issue;
		logic out_load;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic add_last;
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/swsr_ctrl.sv =====
`default_nettype none
`include "sliding_window_spike_rate_defines.svh"
module swsr_ctrl (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             item_valid,
	output logic                            item_stall,
	input  wire  [swsr_pkg::CMD_BITS-1:0]   cmd,
	input  wire  swsr_pkg::stat_t           stat,
	output swsr_pkg::ctrl_t                 ctrl
);
	import swsr_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ADD   = 6'b000100,
		S_DRAIN = 6'b001000,
		S_READ  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_d         = state_q;
		ctrl            = '0;
		ctrl.load       = accept;
		unique case (state_q)
			S_CLEAR: begin
				ctrl.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_ADD:   state_d = S_ADD;
						CMD_READ:  state_d = S_READ;
						CMD_CLEAR: state_d = S_CLEAR;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				ctrl.add_issue = 1'b1;
				if (stat.add_last) begin
					state_d = S_DRAIN;
				end
			end
			// The last window's write-back lands here before a new item may read.
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			S_READ: begin
				ctrl.read_issue = 1'b1;
				state_d         = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`SWSR_ASSERT_NEXT(a_read_goes_read, clk, arst_n, accept && (cmd == CMD_READ), state_q == S_READ, "read transfer did not start a lookup")
	`SWSR_ASSERT_NEXT(a_add_drains, clk, arst_n, ctrl.add_issue && stat.add_last, state_q == S_DRAIN, "sweep end skipped the drain")
	`SWSR_ASSERT_NEXT(a_drain_to_idle, clk, arst_n, state_q == S_DRAIN, state_q == S_IDLE, "drain lasted more than one cycle")

endmodule
`default_nettype wire

// ===== hw/rtl/swsr_datapath.sv =====
`default_nettype none
`include "sliding_window_spike_rate_defines.svh"
module swsr_datapath #(
	parameter int NUM_WINDOWS = 256,
	parameter int COUNT_BITS  = 20
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire  swsr_pkg::ctrl_t                 ctrl,
	output swsr_pkg::stat_t                       stat,
	input  wire  [swsr_pkg::TIME_BITS-1:0]        spike_time,
	input  wire  [swsr_pkg::INDEX_BITS-1:0]       window_index,
	input  wire                                   cfg_wr,
	input  wire  [swsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire  [swsr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output logic [swsr_pkg::INDEX_BITS-1:0]       read_index,
	output logic [swsr_pkg::COUNT_OUT_BITS-1:0]   spike_count,
	output logic [swsr_pkg::RATE_BITS-1:0]        rate,
	output logic                                  out_of_range
);
	import swsr_pkg::*;

	localparam int AW  = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
	localparam int NWB = $clog2(NUM_WINDOWS + 1);
	localparam int LW  = (NWB > WCOUNT_BITS) ? NWB : WCOUNT_BITS;
	// Centers stay below NUM_WINDOWS * 2^32.
	localparam int CW  = TIME_BITS + $clog2(NUM_WINDOWS);
	localparam int EW  = CW + 1;
	localparam int PW  = COUNT_BITS + SCALE_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   step_q;
	logic [HALF_BITS-1:0]   half_q;
	logic [WCOUNT_BITS-1:0] wcount_q;
	logic [SCALE_BITS-1:0]  scale_q;

	logic [LW-1:0]          k_q;
	logic [LW-1:0]          in_use;
	logic [CW-1:0]          centre_q;
	logic [EW-1:0]          ch_q;
	logic [TIME_BITS:0]     th_q;
	logic [TIME_BITS-1:0]   t_q;
	logic                   early_q;
	logic [INDEX_BITS-1:0]  idx_q;
	logic                   in_range;
	logic                   hit;

	logic                   valid_s1;
	logic [AW-1:0]          addr_s1;

	logic [COUNT_BITS-1:0]  window_counts_q [NUM_WINDOWS];
	logic [COUNT_BITS-1:0]  rd_q;
	logic [AW-1:0]          rd_addr;

	logic                   oor;
	logic [PW-1:0]          prod;
	logic [63:0]            prod_wide;
	logic [RATE_BITS-1:0]   rate_v;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RESET;
			step_q   <= STEP_RESET;
			half_q   <= HALF_RESET;
			wcount_q <= WCOUNT_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_START:  start_q  <= cfg_data[TIME_BITS-1:0];
				CFG_STEP:   step_q   <= cfg_data[TIME_BITS-1:0];
				CFG_HALF:   half_q   <= cfg_data[HALF_BITS-1:0];
				CFG_WCOUNT: wcount_q <= cfg_data[WCOUNT_BITS-1:0];
				CFG_SCALE:  scale_q  <= cfg_data[SCALE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_use = (LW'(wcount_q) > LW'(NUM_WINDOWS)) ? LW'(NUM_WINDOWS) : LW'(wcount_q);

	assign in_range        = (k_q < in_use);
	assign stat.add_last   = ((LW+1)'(k_q) + (LW+1)'(1)) >= (LW+1)'(in_use);
	assign stat.clear_last = (k_q == LW'(NUM_WINDOWS - 1));
	assign stat.out_free   = !result_valid || !result_stall;

	// Window sweep counter, shared by the add sweep and the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (ctrl.load) begin
			k_q <= '0;
		end else if (ctrl.add_issue || ctrl.clear_wr) begin
			k_q <= k_q + LW'(1);
		end
	end

	// The center and the upper span edge advance by one step per window.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			centre_q <= CW'(start_q);
			ch_q     <= EW'(start_q) + EW'(half_q);
			th_q     <= (TIME_BITS+1)'(spike_time) + (TIME_BITS+1)'(half_q);
			t_q      <= spike_time;
			early_q  <= (spike_time < start_q);
			idx_q    <= window_index;
		end else if (ctrl.add_issue) begin
			centre_q <= centre_q + CW'(step_q);
			ch_q     <= ch_q + EW'(step_q);
		end
	end

	// Spike lies in (center - half, center + half].
	assign hit = !early_q && in_range && (EW'(th_q) > EW'(centre_q)) && (EW'(t_q) <= ch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.add_issue && hit;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= k_q[AW-1:0];
	end

	assign rd_addr = ctrl.read_issue ? AW'(idx_q) : k_q[AW-1:0];

	// Count store: read window k while the increment of window k-1 is written.
	always_ff @(posedge clk) begin
		if (ctrl.add_issue || ctrl.read_issue) begin
			rd_q <= window_counts_q[rd_addr];
		end
		if (ctrl.clear_wr) begin
			window_counts_q[k_q[AW-1:0]] <= '0;
		end else if (valid_s1 && (rd_q != CNT_MAX)) begin
			window_counts_q[addr_s1] <= rd_q + COUNT_BITS'(1);
		end
	end

	assign oor       = (LW'(idx_q) >= in_use);
	assign prod      = PW'(rd_q) * PW'(scale_q);
	assign prod_wide = 64'(prod);
	assign rate_v    = (prod_wide > RATE_MAX) ? RATE_MAX[RATE_BITS-1:0]
	                                          : prod_wide[RATE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ctrl.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			read_index   <= idx_q;
			spike_count  <= oor ? '0 : COUNT_OUT_BITS'(rd_q);
			rate         <= oor ? '0 : rate_v;
			out_of_range <= oor;
		end
	end

	`SWSR_ASSERT_IMPL(a_no_wr_clash, clk, arst_n, valid_s1, !ctrl.clear_wr, "increment write collided with clearing pass")
	`SWSR_ASSERT_IMPL(a_no_overwrite, clk, arst_n, ctrl.out_load, !result_valid || !result_stall, "result overwritten while stalled")
	`SWSR_ASSERT_NEXT(a_result_retires, clk, arst_n, result_valid && !result_stall && !ctrl.out_load, !result_valid, "result repeated after its transfer")

endmodule
`default_nettype wire

// ===== hw/rtl/sliding_window_spike_rate.sv =====
// Channel  Signals                                     Transfer when
// item     item_valid, item_stall, cmd, spike_time,    item_valid && !item_stall
//          window_index
// result   result_valid, result_stall, read_index,     result_valid && !result_stall
//          spike_count, rate, out_of_range
// config   cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
// An add sweeps n = min(window_count, NUM_WINDOWS) windows, at least 1, with one
// read-modify-write per window on the count memory, then drains the last write-back.
// A read looks up the count, then waits until result_stall no longer holds the result register.
// A clear zeroes all NUM_WINDOWS windows; after reset a clearing pass
// holds item_stall high. Configuration writes are taken in any cycle.
`default_nettype none
module sliding_window_spike_rate #(
	parameter int NUM_WINDOWS = 256,
	parameter int COUNT_BITS  = 20
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   item_valid,
	output logic                                  item_stall,
	input  wire  [swsr_pkg::CMD_BITS-1:0]         cmd,
	input  wire  [swsr_pkg::TIME_BITS-1:0]        spike_time,
	input  wire  [swsr_pkg::INDEX_BITS-1:0]       window_index,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output logic [swsr_pkg::INDEX_BITS-1:0]       read_index,
	output logic [swsr_pkg::COUNT_OUT_BITS-1:0]   spike_count,
	output logic [swsr_pkg::RATE_BITS-1:0]        rate,
	output logic                                  out_of_range,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [swsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire  [swsr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import swsr_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	swsr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	swsr_datapath #(
		.NUM_WINDOWS (NUM_WINDOWS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.spike_time   (spike_time),
		.window_index (window_index),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_index   (read_index),
		.spike_count  (spike_count),
		.rate         (rate),
		.out_of_range (out_of_range)
	);

endmodule
`default_nettype wire
